>>> rtl/core/yay0_pkg.sv
// Shared types, constants and helpers of the Yay0 decompressor core.
`default_nettype none
package yay0_pkg;

    localparam int unsigned WINDOW_BYTES = 4096;
    localparam int unsigned WIN_AW       = 12;
    localparam int unsigned MASK_BITS    = 32;
    localparam int unsigned LONG_BIAS    = 18;
    localparam int unsigned SHORT_BIAS   = 2;

    localparam logic [31:0] HDR_TOTAL_POS = 32'd4;
    localparam logic [31:0] HDR_LINK_POS  = 32'd8;
    localparam logic [31:0] HDR_CHUNK_POS = 32'd12;
    localparam logic [31:0] MASK_START    = 32'd16;

    // Which source stream a read or a range check refers to.
    typedef enum logic [2:0] {
        SEL_TOTAL,
        SEL_LINK_HDR,
        SEL_CHUNK_HDR,
        SEL_MASK,
        SEL_LINK,
        SEL_CHUNK
    } sel_t;

    // Kind of result written to the output register.
    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_ERR,
        KIND_BYTE
    } kind_t;

    typedef struct packed {
        logic  load;
        sel_t  sel;
        logic  start_rd;
        logic  rd_byte;
        logic  shift_in;
        logic  hdr_total;
        logic  hdr_link;
        logic  hdr_chunk;
        logic  take_mask;
        logic  pop_bit;
        logic  take_lit;
        logic  take_link;
        logic  take_long;
        logic  hist_rd;
        logic  emit_hist;
        logic  set_fail;
        logic  out_write;
        kind_t out_kind;
    } cmd_t;

    typedef struct packed {
        logic failed;
        logic header_read;
        logic done;
        logic copy_nz;
        logic bits_zero;
        logic mask_bit;
        logic nib_zero;
        logic rd_ok;
        logic backref_bad;
        logic out_busy;
    } status_t;

    // Number of bytes a read of the given stream takes.
    function automatic logic [2:0] rd_len(input sel_t sel);
        logic [2:0] n;
        case (sel)
            SEL_LINK:  n = 3'd2;
            SEL_CHUNK: n = 3'd1;
            default:   n = 3'd4;
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/yay0_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module yay0_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/yay0_ctrl.sv
// Controller state machine that sequences header, mask, link and copy steps.
`default_nettype none
module yay0_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_valid,
    input  wire logic              op,
    output logic                   s_ready,
    input  wire yay0_pkg::status_t st,
    output yay0_pkg::cmd_t         cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_H_TOTAL,
        ST_H_LINK,
        ST_H_CHUNK,
        ST_CHECK,
        ST_M_TAKE,
        ST_BIT,
        ST_LIT,
        ST_L_TAKE,
        ST_L_LONG,
        ST_BREF,
        ST_HIST,
        ST_EMIT,
        ST_RESP
    } state_t;

    state_t              state_reg, state_next;
    state_t              ret_reg, ret_next;
    logic [2:0]          rd_left_reg, rd_left_next;
    logic                rd_pend_reg, rd_pend_next;
    logic                hist_reg, hist_next;
    yay0_pkg::kind_t     kind_reg, kind_next;

    always_comb
    begin
        cmd          = '0;
        cmd.sel      = yay0_pkg::SEL_MASK;
        cmd.out_kind = yay0_pkg::KIND_ZERO;
        s_ready      = 1'b0;
        state_next   = state_reg;
        ret_next     = ret_reg;
        rd_left_next = rd_left_reg;
        rd_pend_next = rd_pend_reg;
        hist_next    = hist_reg;
        kind_next    = kind_reg;
        case (state_reg)
            ST_IDLE:
            begin
                s_ready = 1'b1;
                if (s_valid)
                begin
                    if (!op)
                    begin
                        cmd.load   = 1'b1;
                        kind_next  = yay0_pkg::KIND_ZERO;
                        state_next = ST_RESP;
                    end
                    else if (st.failed)
                    begin
                        kind_next  = yay0_pkg::KIND_ERR;
                        state_next = ST_RESP;
                    end
                    else if (!st.header_read)
                    begin
                        cmd.sel      = yay0_pkg::SEL_TOTAL;
                        cmd.start_rd = 1'b1;
                        rd_left_next = yay0_pkg::rd_len(yay0_pkg::SEL_TOTAL);
                        rd_pend_next = 1'b0;
                        ret_next     = ST_H_TOTAL;
                        state_next   = ST_RD;
                    end
                    else
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_RD:
            begin
                cmd.rd_byte  = (rd_left_reg != 3'd0);
                cmd.shift_in = rd_pend_reg;
                rd_pend_next = (rd_left_reg != 3'd0);
                if (rd_left_reg != 3'd0)
                begin
                    rd_left_next = rd_left_reg - 3'd1;
                end
                else
                begin
                    state_next = ret_reg;
                end
            end
            ST_H_TOTAL:
            begin
                cmd.hdr_total = 1'b1;
                cmd.sel       = yay0_pkg::SEL_LINK_HDR;
                cmd.start_rd  = 1'b1;
                rd_left_next  = yay0_pkg::rd_len(yay0_pkg::SEL_LINK_HDR);
                rd_pend_next  = 1'b0;
                ret_next      = ST_H_LINK;
                state_next    = ST_RD;
            end
            ST_H_LINK:
            begin
                cmd.hdr_link = 1'b1;
                cmd.sel      = yay0_pkg::SEL_CHUNK_HDR;
                cmd.start_rd = 1'b1;
                rd_left_next = yay0_pkg::rd_len(yay0_pkg::SEL_CHUNK_HDR);
                rd_pend_next = 1'b0;
                ret_next     = ST_H_CHUNK;
                state_next   = ST_RD;
            end
            ST_H_CHUNK:
            begin
                cmd.hdr_chunk = 1'b1;
                state_next    = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.sel = yay0_pkg::SEL_MASK;
                if (st.done)
                begin
                    kind_next  = yay0_pkg::KIND_ZERO;
                    state_next = ST_RESP;
                end
                else if (st.copy_nz)
                begin
                    state_next = ST_HIST;
                end
                else if (st.bits_zero)
                begin
                    if (!st.rd_ok)
                    begin
                        cmd.set_fail = 1'b1;
                        kind_next    = yay0_pkg::KIND_ERR;
                        state_next   = ST_RESP;
                    end
                    else
                    begin
                        cmd.start_rd = 1'b1;
                        rd_left_next = yay0_pkg::rd_len(yay0_pkg::SEL_MASK);
                        rd_pend_next = 1'b0;
                        ret_next     = ST_M_TAKE;
                        state_next   = ST_RD;
                    end
                end
                else
                begin
                    state_next = ST_BIT;
                end
            end
            ST_M_TAKE:
            begin
                cmd.take_mask = 1'b1;
                state_next    = ST_BIT;
            end
            ST_BIT:
            begin
                cmd.pop_bit = 1'b1;
                cmd.sel     = st.mask_bit ? yay0_pkg::SEL_CHUNK : yay0_pkg::SEL_LINK;
                if (!st.rd_ok)
                begin
                    cmd.set_fail = 1'b1;
                    kind_next    = yay0_pkg::KIND_ERR;
                    state_next   = ST_RESP;
                end
                else
                begin
                    cmd.start_rd = 1'b1;
                    rd_left_next = yay0_pkg::rd_len(cmd.sel);
                    rd_pend_next = 1'b0;
                    ret_next     = st.mask_bit ? ST_LIT : ST_L_TAKE;
                    state_next   = ST_RD;
                end
            end
            ST_LIT:
            begin
                cmd.take_lit = 1'b1;
                hist_next    = 1'b0;
                state_next   = ST_EMIT;
            end
            ST_L_TAKE:
            begin
                cmd.take_link = 1'b1;
                cmd.sel       = yay0_pkg::SEL_CHUNK;
                if (!st.nib_zero)
                begin
                    state_next = ST_BREF;
                end
                else if (!st.rd_ok)
                begin
                    cmd.set_fail = 1'b1;
                    kind_next    = yay0_pkg::KIND_ERR;
                    state_next   = ST_RESP;
                end
                else
                begin
                    cmd.start_rd = 1'b1;
                    rd_left_next = yay0_pkg::rd_len(yay0_pkg::SEL_CHUNK);
                    rd_pend_next = 1'b0;
                    ret_next     = ST_L_LONG;
                    state_next   = ST_RD;
                end
            end
            ST_L_LONG:
            begin
                cmd.take_long = 1'b1;
                state_next    = ST_BREF;
            end
            ST_BREF:
            begin
                if (st.backref_bad)
                begin
                    cmd.set_fail = 1'b1;
                    kind_next    = yay0_pkg::KIND_ERR;
                    state_next   = ST_RESP;
                end
                else
                begin
                    state_next = ST_HIST;
                end
            end
            ST_HIST:
            begin
                cmd.hist_rd = 1'b1;
                hist_next   = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!st.out_busy)
                begin
                    cmd.out_write = 1'b1;
                    cmd.out_kind  = yay0_pkg::KIND_BYTE;
                    cmd.emit_hist = hist_reg;
                    state_next    = ST_IDLE;
                end
            end
            ST_RESP:
            begin
                if (!st.out_busy)
                begin
                    cmd.out_write = 1'b1;
                    cmd.out_kind  = kind_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            ret_reg     <= ST_IDLE;
            rd_left_reg <= 3'd0;
            rd_pend_reg <= 1'b0;
            hist_reg    <= 1'b0;
            kind_reg    <= yay0_pkg::KIND_ZERO;
        end
        else
        begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            rd_left_reg <= rd_left_next;
            rd_pend_reg <= rd_pend_next;
            hist_reg    <= hist_next;
            kind_reg    <= kind_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/yay0_dp.sv
// Datapath: decoder registers, source store, history ring and output register.
`default_nettype none
module yay0_dp #(
    parameter int unsigned SOURCE_BYTES = 16384
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire yay0_pkg::cmd_t    cmd,
    output yay0_pkg::status_t      st,
    input  wire logic [13:0]       address,
    input  wire logic [7:0]        data,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output logic                   byte_valid,
    output logic [7:0]             out_byte,
    output logic [31:0]            out_index,
    output logic                   last,
    output logic                   error
);

    localparam int unsigned SAW      = $clog2(SOURCE_BYTES);
    localparam int unsigned WIN_AW_L = yay0_pkg::WIN_AW;

    logic [31:0] total_reg, count_reg, mask_word_reg, acc_reg, rd_ptr_reg;
    logic [31:0] mask_cur_reg, link_cur_reg, chunk_cur_reg;
    logic [5:0]  bits_left_reg;
    logic [8:0]  copy_left_reg;
    logic [12:0] dist_reg;
    logic        failed_reg, header_reg, out_valid_reg;
    logic        byte_valid_reg, last_reg, error_reg;
    logic [7:0]  out_byte_reg;
    logic [31:0] out_index_reg;

    logic [31:0]       addr_ext;
    logic              src_we;
    logic [7:0]        src_rdata, hist_rdata, emit_byte;
    logic [31:0]       chk_pos, start_pos;
    logic [32:0]       chk_end;
    logic [WIN_AW_L-1:0] hist_raddr;
    logic              emit;

    assign addr_ext  = 32'(address);
    assign src_we    = cmd.load && ({18'd0, address} < 32'(SOURCE_BYTES));
    assign hist_raddr = count_reg[WIN_AW_L-1:0] - dist_reg[WIN_AW_L-1:0];
    assign emit      = cmd.out_write && (cmd.out_kind == yay0_pkg::KIND_BYTE);
    assign emit_byte = cmd.emit_hist ? hist_rdata : acc_reg[7:0];

    yay0_ram #(.WIDTH(8), .DEPTH(SOURCE_BYTES)) u_src (
        .clk   (clk),
        .we    (src_we),
        .waddr (addr_ext[SAW-1:0]),
        .wdata (data),
        .re    (cmd.rd_byte),
        .raddr (rd_ptr_reg[SAW-1:0]),
        .rdata (src_rdata)
    );

    yay0_ram #(.WIDTH(8), .DEPTH(yay0_pkg::WINDOW_BYTES)) u_hist (
        .clk   (clk),
        .we    (emit),
        .waddr (count_reg[WIN_AW_L-1:0]),
        .wdata (emit_byte),
        .re    (cmd.hist_rd),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    always_comb
    begin
        case (cmd.sel)
            yay0_pkg::SEL_TOTAL:     start_pos = yay0_pkg::HDR_TOTAL_POS;
            yay0_pkg::SEL_LINK_HDR:  start_pos = yay0_pkg::HDR_LINK_POS;
            yay0_pkg::SEL_CHUNK_HDR: start_pos = yay0_pkg::HDR_CHUNK_POS;
            yay0_pkg::SEL_LINK:      start_pos = link_cur_reg;
            yay0_pkg::SEL_CHUNK:     start_pos = chunk_cur_reg;
            default:                 start_pos = mask_cur_reg;
        endcase
    end

    assign chk_pos = start_pos;
    assign chk_end = {1'b0, chk_pos} + 33'(yay0_pkg::rd_len(cmd.sel));

    assign st.failed      = failed_reg;
    assign st.header_read = header_reg;
    assign st.done        = (count_reg >= total_reg);
    assign st.copy_nz     = (copy_left_reg != 9'd0);
    assign st.bits_zero   = (bits_left_reg == 6'd0);
    assign st.mask_bit    = mask_word_reg[31];
    assign st.nib_zero    = (acc_reg[15:12] == 4'd0);
    assign st.rd_ok       = (chk_end <= 33'(SOURCE_BYTES));
    assign st.backref_bad = (32'(dist_reg) > count_reg);
    assign st.out_busy    = out_valid_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            count_reg     <= '0;
            mask_word_reg <= '0;
            bits_left_reg <= '0;
            mask_cur_reg  <= yay0_pkg::MASK_START;
            link_cur_reg  <= '0;
            chunk_cur_reg <= '0;
            copy_left_reg <= '0;
            dist_reg      <= '0;
            failed_reg    <= 1'b0;
            header_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                total_reg     <= '0;
                count_reg     <= '0;
                mask_word_reg <= '0;
                bits_left_reg <= '0;
                mask_cur_reg  <= yay0_pkg::MASK_START;
                link_cur_reg  <= '0;
                chunk_cur_reg <= '0;
                copy_left_reg <= '0;
                dist_reg      <= '0;
                failed_reg    <= 1'b0;
                header_reg    <= 1'b0;
            end
            if (cmd.hdr_total)
            begin
                total_reg <= acc_reg;
            end
            if (cmd.hdr_link)
            begin
                link_cur_reg <= acc_reg;
            end
            if (cmd.hdr_chunk)
            begin
                chunk_cur_reg <= acc_reg;
                header_reg    <= 1'b1;
            end
            if (cmd.take_mask)
            begin
                mask_word_reg <= acc_reg;
                mask_cur_reg  <= mask_cur_reg + 32'd4;
                bits_left_reg <= 6'(yay0_pkg::MASK_BITS);
            end
            if (cmd.pop_bit)
            begin
                mask_word_reg <= {mask_word_reg[30:0], 1'b0};
                bits_left_reg <= bits_left_reg - 6'd1;
            end
            if (cmd.take_lit)
            begin
                chunk_cur_reg <= chunk_cur_reg + 32'd1;
            end
            if (cmd.take_link)
            begin
                link_cur_reg <= link_cur_reg + 32'd2;
                dist_reg     <= {1'b0, acc_reg[11:0]} + 13'd1;
                if (acc_reg[15:12] == 4'd0)
                begin
                    copy_left_reg <= '0;
                end
                else
                begin
                    copy_left_reg <= 9'(acc_reg[15:12]) + 9'(yay0_pkg::SHORT_BIAS);
                end
            end
            if (cmd.take_long)
            begin
                chunk_cur_reg <= chunk_cur_reg + 32'd1;
                copy_left_reg <= 9'(acc_reg[7:0]) + 9'(yay0_pkg::LONG_BIAS);
            end
            if (cmd.set_fail)
            begin
                failed_reg <= 1'b1;
            end
            if (emit)
            begin
                count_reg <= count_reg + 32'd1;
                if (cmd.emit_hist)
                begin
                    copy_left_reg <= copy_left_reg - 9'd1;
                end
            end
            if (cmd.out_write)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Read pointer, byte accumulator and output payload need no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.start_rd)
        begin
            rd_ptr_reg <= start_pos;
            acc_reg    <= '0;
        end
        else
        begin
            if (cmd.rd_byte)
            begin
                rd_ptr_reg <= rd_ptr_reg + 32'd1;
            end
            if (cmd.shift_in)
            begin
                acc_reg <= {acc_reg[23:0], src_rdata};
            end
        end
        if (cmd.out_write)
        begin
            byte_valid_reg <= emit;
            out_byte_reg   <= emit ? emit_byte : 8'd0;
            out_index_reg  <= emit ? count_reg : 32'd0;
            last_reg       <= emit && ((count_reg + 32'd1) == total_reg);
            error_reg      <= (cmd.out_kind == yay0_pkg::KIND_ERR);
        end
    end

    assign out_valid  = out_valid_reg;
    assign byte_valid = byte_valid_reg;
    assign out_byte   = out_byte_reg;
    assign out_index  = out_index_reg;
    assign last       = last_reg;
    assign error      = error_reg;

endmodule
`default_nettype wire

>>> rtl/core/yay0_lz_decompressor_core.sv
// Top level of the Yay0 LZ decompressor core.
//
// This core decodes a Yay0 compressed image one byte per fetch request. A load
// request (tuser low) writes one compressed byte into the on-chip source store
// and rewinds the decoder; a fetch request (tuser high) returns the next decoded
// byte with its index, tlast on the final byte, and an error flag that stays set
// once a link reaches back before the start of output or any read runs past the
// source store, until the next load. Every request gets exactly one response;
// loads and fetches past the end return all-zero fields. The core works on one
// request at a time and sets its timing by byte reads of the single source
// store port, one byte per cycle. A load only writes the store; a fetch reads
// the literal or link bytes it needs, a new 32-bit mask word when the current
// one is used up and, on the first fetch after a load, the header, while a
// fetch that replays a back-reference byte reads the history ring instead. A
// response that finds the output register still full waits until it drains.
// The next request is accepted while the previous response still waits in
// the output register.
`default_nettype none
module yay0_lz_decompressor_core #(
    parameter int unsigned SOURCE_BYTES = 16384
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // address[13:0], data[21:14], zero pad
    input  wire logic        s_axis_tuser,   // op: 0 load, 1 fetch
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // out_byte[7:0], out_index[39:8]
    output logic [1:0]       m_axis_tuser,   // byte_valid[0], error[1]
    output logic             m_axis_tlast    // last
);

    yay0_pkg::cmd_t    cmd;
    yay0_pkg::status_t st;
    logic              byte_valid, last, error;
    logic [7:0]        out_byte;
    logic [31:0]       out_index;

    yay0_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .op      (s_axis_tuser),
        .s_ready (s_axis_tready),
        .st      (st),
        .cmd     (cmd)
    );

    yay0_dp #(.SOURCE_BYTES(SOURCE_BYTES)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .st         (st),
        .address    (s_axis_tdata[13:0]),
        .data       (s_axis_tdata[21:14]),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .byte_valid (byte_valid),
        .out_byte   (out_byte),
        .out_index  (out_index),
        .last       (last),
        .error      (error)
    );

    assign m_axis_tdata = {out_index, out_byte};
    assign m_axis_tuser = {error, byte_valid};
    assign m_axis_tlast = last;

endmodule
`default_nettype wire
